[sv/siie_pkg.sv]
`default_nettype none

package siie_pkg;

	localparam int MAX_ORBITALS_DEF = 64;
	localparam int IDX_W = 6;
	localparam int ORD_W = 24;
	localparam int CNT_W = 7;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		MODE_NONE        = 2'd0,
		MODE_PAIR_SWAP   = 2'd1,
		MODE_WITHIN_PAIR = 2'd2,
		MODE_EIGHT_FOLD  = 2'd3
	} mode_t;

	typedef enum logic {
		REG_ORBITAL_COUNT = 1'b0,
		REG_SYMMETRY_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] orbital_count;
		mode_t            mode;
		logic             rewind;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] index_i;
		logic [IDX_W-1:0] index_j;
		logic [IDX_W-1:0] index_k;
		logic [IDX_W-1:0] index_l;
		logic [ORD_W-1:0] ordinal;
		logic             is_last;
		logic             valid_res;
	} result_t;

endpackage

`default_nettype wire

[sv/siie_in_if.sv]
`default_nettype none

interface siie_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

[sv/siie_out_if.sv]
`default_nettype none

interface siie_out_if;
	logic                        valid;
	logic                        ready;
	logic [siie_pkg::IDX_W-1:0] index_i;
	logic [siie_pkg::IDX_W-1:0] index_j;
	logic [siie_pkg::IDX_W-1:0] index_k;
	logic [siie_pkg::IDX_W-1:0] index_l;
	logic [siie_pkg::ORD_W-1:0] ordinal;
	logic                        is_last;
	logic                        valid_res;

	modport source (
		output valid, output index_i, output index_j, output index_k, output index_l,
		output ordinal, output is_last, output valid_res, input ready
	);
	modport sink (
		input valid, input index_i, input index_j, input index_k, input index_l,
		input ordinal, input is_last, input valid_res, output ready
	);
endinterface

`default_nettype wire

[sv/siie_cfg_regs.sv]
`default_nettype none

module siie_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [siie_pkg::APB_AW-1:0] paddr,
	input  wire logic [siie_pkg::APB_DW-1:0] pwdata,
	output logic      [siie_pkg::APB_DW-1:0] prdata,
	output logic                              pready,
	output siie_pkg::cfg_t                    cfg
);

	logic [siie_pkg::CNT_W-1:0] orbital_count_q;
	siie_pkg::mode_t            mode_q;
	siie_pkg::reg_idx_t         sel_idx;
	logic                       wr_en;

	assign pready  = 1'b1;
	assign sel_idx = siie_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbital_count_q <= siie_pkg::CNT_W'(1);
			mode_q          <= siie_pkg::MODE_NONE;
		end else if (wr_en) begin
			case (sel_idx)
				siie_pkg::REG_ORBITAL_COUNT: orbital_count_q <= pwdata[siie_pkg::CNT_W-1:0];
				siie_pkg::REG_SYMMETRY_MODE: mode_q <= siie_pkg::mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	// byte lane bits only matter on reads: unaligned reads return zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (sel_idx)
				siie_pkg::REG_ORBITAL_COUNT:
					prdata = {{(siie_pkg::APB_DW-siie_pkg::CNT_W){1'b0}}, orbital_count_q};
				siie_pkg::REG_SYMMETRY_MODE:
					prdata = {{(siie_pkg::APB_DW-2){1'b0}}, mode_q};
				default: prdata = '0;
			endcase
		end
	end

	assign cfg.orbital_count = orbital_count_q;
	assign cfg.mode          = mode_q;
	assign cfg.rewind        = wr_en;

endmodule

`default_nettype wire

[sv/siie_next.sv]
`default_nettype none

module siie_next #(
	parameter int MAX_ORBITALS = siie_pkg::MAX_ORBITALS_DEF,
	parameter int CW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1
) (
	input  wire logic                         restart,
	input  wire logic [siie_pkg::CNT_W-1:0]  orbital_count,
	input  wire siie_pkg::mode_t              mode,
	input  wire logic [CW-1:0]                cur_i,
	input  wire logic [CW-1:0]                cur_j,
	input  wire logic [CW-1:0]                cur_k,
	input  wire logic [CW-1:0]                cur_l,
	input  wire logic [siie_pkg::ORD_W-1:0]  count,
	input  wire logic                         exhausted,
	output logic      [CW-1:0]                nxt_i,
	output logic      [CW-1:0]                nxt_j,
	output logic      [CW-1:0]                nxt_k,
	output logic      [CW-1:0]                nxt_l,
	output logic      [siie_pkg::ORD_W-1:0]  nxt_count,
	output logic                              nxt_exhausted,
	output siie_pkg::result_t                 res
);

	localparam int NW = CW + 1;
	localparam int EW = (NW > siie_pkg::CNT_W) ? NW : siie_pkg::CNT_W;

	logic [CW-1:0] si, sj, sk, sl;
	logic [siie_pkg::ORD_W-1:0] so;
	logic se;
	logic [EW-1:0] cnt_ext, n_full;
	logic [NW-1:0] n, i1, j1, k1, l1, lmax;
	logic [CW-1:0] ai, aj, ak, al;
	logic more;

	function automatic logic [siie_pkg::IDX_W-1:0] to_idx(input logic [CW-1:0] v);
		logic [CW+siie_pkg::IDX_W-1:0] w;
		w = {{siie_pkg::IDX_W{1'b0}}, v};
		return w[siie_pkg::IDX_W-1:0];
	endfunction

	// clamp n into 1..MAX_ORBITALS
	always_comb begin
		cnt_ext = EW'(orbital_count);
		if (cnt_ext == '0)
			n_full = EW'(1);
		else if (cnt_ext > EW'(MAX_ORBITALS))
			n_full = EW'(MAX_ORBITALS);
		else
			n_full = cnt_ext;
		n = n_full[NW-1:0];
	end

	always_comb begin
		if (restart) begin
			si = '0; sj = '0; sk = '0; sl = '0;
			so = '0;
			se = 1'b0;
		end else begin
			si = cur_i; sj = cur_j; sk = cur_k; sl = cur_l;
			so = count;
			se = exhausted;
		end
	end

	always_comb begin
		i1 = NW'(si) + NW'(1);
		j1 = NW'(sj) + NW'(1);
		k1 = NW'(sk) + NW'(1);
		l1 = NW'(sl) + NW'(1);
		lmax = (sk == si) ? NW'(sj) : NW'(sk);
		ai = si; aj = sj; ak = sk; al = sl;
		more = 1'b1;
		case (mode)
			siie_pkg::MODE_NONE: begin
				if (l1 < n) begin
					al = l1[CW-1:0];
				end else begin
					al = '0;
					if (k1 < n) begin
						ak = k1[CW-1:0];
					end else begin
						ak = '0;
						if (j1 < n) begin
							aj = j1[CW-1:0];
						end else begin
							aj = '0;
							ai = i1[CW-1:0];
							more = (i1 < n);
						end
					end
				end
			end
			siie_pkg::MODE_PAIR_SWAP: begin
				if (l1 < n) begin
					al = l1[CW-1:0];
				end else if (k1 < n) begin
					ak = k1[CW-1:0];
					al = '0;
				end else if (j1 < n) begin
					// kl restarts at the new ij pair
					aj = j1[CW-1:0];
					ak = si;
					al = j1[CW-1:0];
				end else begin
					ai = i1[CW-1:0];
					aj = '0;
					ak = i1[CW-1:0];
					al = '0;
					more = (i1 < n);
				end
			end
			siie_pkg::MODE_WITHIN_PAIR: begin
				if (l1 < n) begin
					al = l1[CW-1:0];
				end else if (k1 < n) begin
					ak = k1[CW-1:0];
					al = k1[CW-1:0];
				end else if (j1 < n) begin
					aj = j1[CW-1:0];
					ak = '0;
					al = '0;
				end else begin
					ai = i1[CW-1:0];
					aj = i1[CW-1:0];
					ak = '0;
					al = '0;
					more = (i1 < n);
				end
			end
			siie_pkg::MODE_EIGHT_FOLD: begin
				if (l1 <= lmax) begin
					al = l1[CW-1:0];
				end else begin
					al = '0;
					if (k1 <= NW'(si)) begin
						ak = k1[CW-1:0];
					end else begin
						ak = '0;
						if (j1 <= NW'(si)) begin
							aj = j1[CW-1:0];
						end else begin
							aj = '0;
							ai = i1[CW-1:0];
							more = (i1 < n);
						end
					end
				end
			end
			default: more = 1'b0;
		endcase
	end

	always_comb begin
		if (se) begin
			res = '0;
			nxt_i = si; nxt_j = sj; nxt_k = sk; nxt_l = sl;
			nxt_count = so;
			nxt_exhausted = 1'b1;
		end else begin
			res.index_i   = to_idx(si);
			res.index_j   = to_idx(sj);
			res.index_k   = to_idx(sk);
			res.index_l   = to_idx(sl);
			res.ordinal   = so;
			res.is_last   = !more;
			res.valid_res = 1'b1;
			nxt_i = more ? ai : '0;
			nxt_j = more ? aj : '0;
			nxt_k = more ? ak : '0;
			nxt_l = more ? al : '0;
			nxt_count = so + siie_pkg::ORD_W'(1);
			nxt_exhausted = !more;
		end
	end

endmodule

`default_nettype wire

[sv/symmetric_integral_index_enumerator_unit.sv]
`default_nettype none

// Four-index tuple enumerator for symmetric two-electron integrals. Every input
// beat (restart = 1 rewinds first) returns one result beat with the next
// tuple (i,j,k,l) of the list chosen by symmetry_mode over orbital_count
// orbitals, its ordinal and a last mark; once the list is done each beat
// returns valid_res = 0 with all fields zero until a restart or a register
// write, either of which rewinds to the first tuple. Throughput is one beat
// per cycle unless the output stalls; a result shows in the cycle after its
// input beat via increment-and-compare cursor logic and one result register.
// The input is held off only while a result beat waits with ready low; a new
// beat enters in the same cycle that the waiting result leaves.
// Registers: orbital_count at byte 0x0, symmetry_mode at byte 0x4; write them
// only while no beat is in flight.
module symmetric_integral_index_enumerator_unit #(
	parameter int MAX_ORBITALS = siie_pkg::MAX_ORBITALS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [siie_pkg::APB_AW-1:0] paddr,
	input  wire logic [siie_pkg::APB_DW-1:0] pwdata,
	output logic      [siie_pkg::APB_DW-1:0] prdata,
	output logic                              pready,
	siie_in_if.sink                           in_ch,
	siie_out_if.source                        out_ch
);

	localparam int CW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

	siie_pkg::cfg_t cfg;

	logic [CW-1:0] cur_i_q, cur_j_q, cur_k_q, cur_l_q;
	logic [siie_pkg::ORD_W-1:0] count_q;
	logic exhausted_q;

	logic [CW-1:0] nxt_i, nxt_j, nxt_k, nxt_l;
	logic [siie_pkg::ORD_W-1:0] nxt_count;
	logic nxt_exhausted;
	siie_pkg::result_t res;

	siie_pkg::result_t res_s1;
	logic out_valid_s1;
	logic accept;

	siie_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	siie_next #(
		.MAX_ORBITALS (MAX_ORBITALS),
		.CW           (CW)
	) u_next (
		.restart       (in_ch.restart),
		.orbital_count (cfg.orbital_count),
		.mode          (cfg.mode),
		.cur_i         (cur_i_q),
		.cur_j         (cur_j_q),
		.cur_k         (cur_k_q),
		.cur_l         (cur_l_q),
		.count         (count_q),
		.exhausted     (exhausted_q),
		.nxt_i         (nxt_i),
		.nxt_j         (nxt_j),
		.nxt_k         (nxt_k),
		.nxt_l         (nxt_l),
		.nxt_count     (nxt_count),
		.nxt_exhausted (nxt_exhausted),
		.res           (res)
	);

	assign in_ch.ready = !out_valid_s1 || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// register writes rewind the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_i_q     <= '0;
			cur_j_q     <= '0;
			cur_k_q     <= '0;
			cur_l_q     <= '0;
			count_q     <= '0;
			exhausted_q <= 1'b0;
		end else if (cfg.rewind) begin
			cur_i_q     <= '0;
			cur_j_q     <= '0;
			cur_k_q     <= '0;
			cur_l_q     <= '0;
			count_q     <= '0;
			exhausted_q <= 1'b0;
		end else if (accept) begin
			cur_i_q     <= nxt_i;
			cur_j_q     <= nxt_j;
			cur_k_q     <= nxt_k;
			cur_l_q     <= nxt_l;
			count_q     <= nxt_count;
			exhausted_q <= nxt_exhausted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_ch.valid     = out_valid_s1;
	assign out_ch.index_i   = res_s1.index_i;
	assign out_ch.index_j   = res_s1.index_j;
	assign out_ch.index_k   = res_s1.index_k;
	assign out_ch.index_l   = res_s1.index_l;
	assign out_ch.ordinal   = res_s1.ordinal;
	assign out_ch.is_last   = res_s1.is_last;
	assign out_ch.valid_res = res_s1.valid_res;

endmodule

`default_nettype wire

[sv/siie_checker.sv]
`default_nettype none

module siie_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [siie_pkg::IDX_W-1:0] index_i,
	input wire logic [siie_pkg::IDX_W-1:0] index_j,
	input wire logic [siie_pkg::IDX_W-1:0] index_k,
	input wire logic [siie_pkg::IDX_W-1:0] index_l,
	input wire logic [siie_pkg::ORD_W-1:0] ordinal,
	input wire logic                        is_last,
	input wire logic                        valid_res
);

	// a stalled result beat holds its ordinal, its marks and indices i and l
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ordinal) && $stable(is_last)
			&& $stable(valid_res) && $stable(index_i) && $stable(index_l))
		else $error("stalled result beat changed");

	// empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// an accepted input beat shows up as a result beat next cycle
	a_one_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result beat missing after accepted input beat");

	// exhausted beats carry all-zero fields and no last mark
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> !is_last && ordinal == '0 && index_i == '0
			&& index_j == '0 && index_k == '0 && index_l == '0)
		else $error("exhausted beat with nonzero fields");

endmodule

bind symmetric_integral_index_enumerator_unit siie_checker u_siie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.index_i   (out_ch.index_i),
	.index_j   (out_ch.index_j),
	.index_k   (out_ch.index_k),
	.index_l   (out_ch.index_l),
	.ordinal   (out_ch.ordinal),
	.is_last   (out_ch.is_last),
	.valid_res (out_ch.valid_res)
);

`default_nettype wire
